FILE: sv/halfband_decimator_by_two_macros.svh
// Assertion macros for the halfband decimator; clock clk, reset rst_n.
`ifndef HALFBAND_DECIMATOR_BY_TWO_MACROS_SVH
`define HALFBAND_DECIMATOR_BY_TWO_MACROS_SVH

`ifndef SYNTH
`define HBD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbd assertion failed");
`define HBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbd assertion failed");
`else
`define HBD_ASSERT_SAME(label, ante, cons)
`define HBD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/hbd_pkg.sv
`default_nettype none

package hbd_pkg;

  localparam int EVEN_TAPS   = 16;
  localparam int ODD_DELAY   = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 18;
  localparam int ACC_BITS    = 48;

  localparam int TAP_BITS   = $clog2(EVEN_TAPS);
  localparam int IDX_BITS   = 5;
  localparam int FUNC_BITS  = 2;
  localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
  localparam int RND_BITS   = ACC_BITS + 1;
  localparam int QUO_BITS   = RND_BITS - (COEF_BITS - 1);

  localparam int IN_SAMPLE_LSB = 0;
  localparam int IN_INDEX_LSB  = IN_SAMPLE_LSB + SAMPLE_BITS;
  localparam int IN_VALUE_LSB  = IN_INDEX_LSB + IDX_BITS;
  localparam int IN_USED_BITS  = IN_VALUE_LSB + COEF_BITS;
  localparam int IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_COEF   = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVEN_MAC,
    ST_EVEN_LAST,
    ST_ODD_MUL,
    ST_ODD_ACC,
    ST_ODD_OUT
  } state_t;

  typedef struct packed {
    logic                latch;
    logic                coef_wr;
    logic                clear;
    logic                acc_clr;
    logic                mul_even;
    logic                mul_odd;
    logic                acc_add;
    logic                hist_shift;
    logic                result_ld;
    logic [TAP_BITS-1:0] tap;
  } hbd_cmd_t;

  typedef struct packed {
    logic out_free;
  } hbd_stat_t;

endpackage

`default_nettype wire

FILE: sv/hbd_ctrl.sv
`default_nettype none

`include "halfband_decimator_by_two_macros.svh"

module hbd_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic [hbd_pkg::FUNC_BITS-1:0]   in_func,
  output logic                                 in_ready,
  input  wire hbd_pkg::hbd_stat_t              stat,
  output hbd_pkg::hbd_cmd_t                    cmd
);

  localparam logic [hbd_pkg::TAP_BITS-1:0] TAP_LAST =
    hbd_pkg::TAP_BITS'(hbd_pkg::EVEN_TAPS - 1);

  hbd_pkg::state_t               state_r, state_nxt;
  logic [hbd_pkg::TAP_BITS-1:0]  tap_r, tap_nxt;
  logic                          phase_r, phase_nxt;
  logic                          accept;
  logic                          is_sample;

  assign accept    = in_valid && (state_r == hbd_pkg::ST_IDLE);
  assign is_sample = (in_func == hbd_pkg::FUNC_SAMPLE);

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    phase_nxt = phase_r;
    case (state_r)
      hbd_pkg::ST_IDLE: begin
        if (accept && (in_func == hbd_pkg::FUNC_CLEAR)) begin
          phase_nxt = 1'b0;
        end else if (accept && is_sample) begin
          if (phase_r) begin
            state_nxt = hbd_pkg::ST_ODD_MUL;
          end else begin
            state_nxt = hbd_pkg::ST_EVEN_MAC;
            tap_nxt   = '0;
          end
        end
      end
      hbd_pkg::ST_EVEN_MAC: begin
        tap_nxt = tap_r + 1'b1;
        if (tap_r == TAP_LAST) begin
          state_nxt = hbd_pkg::ST_EVEN_LAST;
        end
      end
      hbd_pkg::ST_EVEN_LAST: begin
        state_nxt = hbd_pkg::ST_IDLE;
        phase_nxt = 1'b1;
      end
      hbd_pkg::ST_ODD_MUL: begin
        state_nxt = hbd_pkg::ST_ODD_ACC;
      end
      hbd_pkg::ST_ODD_ACC: begin
        state_nxt = hbd_pkg::ST_ODD_OUT;
      end
      hbd_pkg::ST_ODD_OUT: begin
        if (stat.out_free) begin
          state_nxt = hbd_pkg::ST_IDLE;
          phase_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = hbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.tap      = tap_r;
    in_ready     = (state_r == hbd_pkg::ST_IDLE);
    cmd.latch    = accept;
    cmd.coef_wr  = accept && (in_func == hbd_pkg::FUNC_COEF);
    cmd.clear    = accept && (in_func == hbd_pkg::FUNC_CLEAR);
    case (state_r)
      hbd_pkg::ST_IDLE: begin
        cmd.acc_clr = accept && is_sample && !phase_r;
      end
      hbd_pkg::ST_EVEN_MAC: begin
        cmd.mul_even = 1'b1;
        cmd.acc_add  = (tap_r != '0);
      end
      hbd_pkg::ST_EVEN_LAST: begin
        cmd.acc_add    = 1'b1;
        cmd.hist_shift = 1'b1;
      end
      hbd_pkg::ST_ODD_MUL: begin
        cmd.mul_odd = 1'b1;
      end
      hbd_pkg::ST_ODD_ACC: begin
        cmd.acc_add = 1'b1;
      end
      hbd_pkg::ST_ODD_OUT: begin
        cmd.result_ld = stat.out_free;
        cmd.acc_clr   = stat.out_free;
      end
      default: begin
        cmd.acc_clr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hbd_pkg::ST_IDLE;
      tap_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      phase_r <= phase_nxt;
    end
  end

  `HBD_ASSERT_NEXT(a_mac_ends, (state_r == hbd_pkg::ST_EVEN_MAC) && (tap_r == TAP_LAST), (state_r == hbd_pkg::ST_EVEN_LAST))
  `HBD_ASSERT_NEXT(a_even_sets_phase, state_r == hbd_pkg::ST_EVEN_LAST, phase_r)
  `HBD_ASSERT_SAME(a_odd_needs_phase, (state_r == hbd_pkg::ST_ODD_MUL) || (state_r == hbd_pkg::ST_ODD_ACC), phase_r)

endmodule

`default_nettype wire

FILE: sv/hbd_datapath.sv
`default_nettype none

module hbd_datapath (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire hbd_pkg::hbd_cmd_t                       cmd,
  input  wire logic signed [hbd_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  wire logic [hbd_pkg::IDX_BITS-1:0]            in_coef_index,
  input  wire logic signed [hbd_pkg::COEF_BITS-1:0]    in_coef_value,
  output logic signed [hbd_pkg::SAMPLE_BITS-1:0]       res_sample,
  output logic                                         res_sat
);

  localparam int SB = hbd_pkg::SAMPLE_BITS;
  localparam int HIST_DEPTH = hbd_pkg::EVEN_TAPS - 1;
  localparam int SHIFT = hbd_pkg::COEF_BITS - 1;
  localparam int EXT_BITS = hbd_pkg::ACC_BITS - hbd_pkg::PROD_BITS;

  logic signed [SB-1:0]                      sample_r;
  logic signed [SB-1:0]                      even_hist_r [HIST_DEPTH];
  logic signed [SB-1:0]                      odd_dly_r   [hbd_pkg::ODD_DELAY];
  logic signed [hbd_pkg::COEF_BITS-1:0]      even_coef_r [hbd_pkg::EVEN_TAPS];
  logic signed [hbd_pkg::COEF_BITS-1:0]      center_coef_r;
  logic signed [hbd_pkg::PROD_BITS-1:0]      prod_r;
  logic [hbd_pkg::ACC_BITS-1:0]              acc_r;

  logic signed [SB-1:0]                      tap_data [hbd_pkg::EVEN_TAPS];
  logic signed [SB-1:0]                      mul_data;
  logic signed [hbd_pkg::COEF_BITS-1:0]      mul_coef;
  logic signed [hbd_pkg::RND_BITS-1:0]       rnd;
  logic signed [hbd_pkg::QUO_BITS-1:0]       quo;
  logic                                      fits;

  assign tap_data[0] = sample_r;
  for (genvar g = 1; g < hbd_pkg::EVEN_TAPS; g++) begin : g_tap
    assign tap_data[g] = even_hist_r[g-1];
  end

  always_comb begin
    if (cmd.mul_odd) begin
      mul_data = odd_dly_r[hbd_pkg::ODD_DELAY-1];
      mul_coef = center_coef_r;
    end else begin
      mul_data = tap_data[cmd.tap];
      mul_coef = even_coef_r[cmd.tap];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sample_r <= in_sample;
    end
    if (cmd.mul_even || cmd.mul_odd) begin
      prod_r <= mul_coef * mul_data;
    end
    if (cmd.coef_wr) begin
      if (in_coef_index < hbd_pkg::IDX_BITS'(hbd_pkg::EVEN_TAPS)) begin
        even_coef_r[in_coef_index[hbd_pkg::TAP_BITS-1:0]] <= in_coef_value;
      end else if (in_coef_index == hbd_pkg::IDX_BITS'(hbd_pkg::EVEN_TAPS)) begin
        center_coef_r <= in_coef_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      acc_r <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        even_hist_r[i] <= '0;
      end
      for (int i = 0; i < hbd_pkg::ODD_DELAY; i++) begin
        odd_dly_r[i] <= '0;
      end
    end else begin
      if (cmd.acc_clr) begin
        acc_r <= '0;
      end else if (cmd.acc_add) begin
        acc_r <= acc_r + {{EXT_BITS{prod_r[hbd_pkg::PROD_BITS-1]}}, prod_r};
      end
      if (cmd.hist_shift) begin
        even_hist_r[0] <= sample_r;
        for (int i = 1; i < HIST_DEPTH; i++) begin
          even_hist_r[i] <= even_hist_r[i-1];
        end
      end
      if (cmd.mul_odd) begin
        odd_dly_r[0] <= sample_r;
        for (int i = 1; i < hbd_pkg::ODD_DELAY; i++) begin
          odd_dly_r[i] <= odd_dly_r[i-1];
        end
      end
    end
  end

  // round half up, then floor by the coefficient scale
  assign rnd  = $signed({acc_r[hbd_pkg::ACC_BITS-1], acc_r})
              + (hbd_pkg::RND_BITS'(1) << (SHIFT - 1));
  assign quo  = rnd[hbd_pkg::RND_BITS-1:SHIFT];
  assign fits = (quo[hbd_pkg::QUO_BITS-1:SB-1] == '0) || (quo[hbd_pkg::QUO_BITS-1:SB-1] == '1);

  always_comb begin
    res_sat = !fits;
    if (fits) begin
      res_sample = quo[SB-1:0];
    end else if (quo[hbd_pkg::QUO_BITS-1]) begin
      res_sample = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res_sample = {1'b0, {(SB-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

FILE: sv/halfband_decimator_by_two.sv
// Channel | Dir | Ports              | Payload
// in      | in  | in_tvalid/tready   | tuser: func; tdata: sample, coef_index, coef_value
// out     | out | out_tvalid/tready  | tdata: out_sample; tuser: saturated
// Even sample: accept, 16 passes through the single shared multiply-accumulate,
//   then a drain/shift step. Odd sample: accept, multiply, accumulate, then an output
//   step that waits for the output register. Coefficient write, clear, unused code: accept only.
// Reset clears phase, accumulator and both histories at once; coefficients keep
//   no reset value and must be written before use.
// A full output register stalls only the final step of an odd sample.
`default_nettype none

`include "halfband_decimator_by_two_macros.svh"

module halfband_decimator_by_two (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [23:0] sample, [28:24] coef_index, [46:29] coef_value, [47] unused
  input  wire logic [hbd_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // [1:0] func
  input  wire logic [hbd_pkg::FUNC_BITS-1:0]       in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [23:0] out_sample
  output logic [hbd_pkg::OUT_DATA_BITS-1:0]        out_tdata,
  // [0] saturated
  output logic [0:0]                               out_tuser
);

  hbd_pkg::hbd_cmd_t                          cmd;
  hbd_pkg::hbd_stat_t                         stat;
  logic signed [hbd_pkg::SAMPLE_BITS-1:0]     res_sample;
  logic                                       res_sat;
  logic                                       out_valid_r, out_valid_nxt;
  logic signed [hbd_pkg::SAMPLE_BITS-1:0]     out_sample_r;
  logic                                       out_sat_r;

  assign stat.out_free = !out_valid_r || out_tready;

  hbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hbd_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_sample     (in_tdata[hbd_pkg::IN_INDEX_LSB-1:hbd_pkg::IN_SAMPLE_LSB]),
    .in_coef_index (in_tdata[hbd_pkg::IN_VALUE_LSB-1:hbd_pkg::IN_INDEX_LSB]),
    .in_coef_value (in_tdata[hbd_pkg::IN_USED_BITS-1:hbd_pkg::IN_VALUE_LSB]),
    .res_sample    (res_sample),
    .res_sat       (res_sat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.result_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_ld) begin
      out_sample_r <= res_sample;
      out_sat_r    <= res_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = hbd_pkg::OUT_DATA_BITS'(out_sample_r);
  assign out_tuser  = out_sat_r;

  `HBD_ASSERT_SAME(a_load_into_free, cmd.result_ld, (!out_valid_r || out_tready))
  `HBD_ASSERT_SAME(a_busy_on_load, cmd.result_ld, !in_tready)
  `HBD_ASSERT_NEXT(a_load_shows, cmd.result_ld, out_tvalid)

endmodule

`default_nettype wire
